// ===== hdl/qenc_pkg.sv =====
// types, constants and step rules shared by the encoder reporter
package qenc_pkg;

    typedef logic signed [3:0] step_count_t;
    typedef logic [1:0]        direction_t;

    localparam direction_t DIR_NONE  = 2'd0;
    localparam direction_t DIR_RIGHT = 2'd1;
    localparam direction_t DIR_LEFT  = 2'd3;

    localparam step_count_t COUNT_RIGHT = 4'sd4;
    localparam step_count_t COUNT_LEFT  = -4'sd4;

    localparam int unsigned BUTTON_WIDTH   = 15;
    localparam int unsigned REPORT_ENC_MAX = 4;
    localparam logic [15:0] HOLD_TICKS_RESET = 16'd1563;

    typedef struct packed {
        step_count_t count;
        direction_t  dir;
        logic        detent;
    } rule_result_t;

    typedef struct packed {
        direction_t dir;
        logic       detent;
    } enc_status_t;

    // one rule set (channel a or channel b) followed by detent and rest checks
    function automatic rule_result_t apply_rule(
        input step_count_t c,
        input direction_t  dir,
        input logic        a,
        input logic        b,
        input logic        on_b
    );
        rule_result_t r;
        logic         dec;
        logic         inc;
        r.count  = c;
        r.dir    = dir;
        r.detent = 1'b0;
        if (on_b) begin
            dec = (c == -4'sd1 && !a && !b) || (c == -4'sd3 && a && b);
            inc = (c == 4'sd0 && a && !b) || (c == 4'sd2 && !a && b);
        end else begin
            dec = (c == 4'sd0 && !a && b) || (c == -4'sd2 && a && !b);
            inc = (c == 4'sd1 && !a && !b) || (c == 4'sd3 && a && b);
        end
        if (dec) begin
            r.count = c - 4'sd1;
        end else if (inc) begin
            r.count = c + 4'sd1;
        end
        if (r.count == COUNT_RIGHT || r.count == COUNT_LEFT) begin
            r.dir    = (r.count == COUNT_RIGHT) ? DIR_RIGHT : DIR_LEFT;
            r.count  = 4'sd0;
            r.detent = 1'b1;
        end
        if (a && b) begin
            r.count = 4'sd0;
        end
        return r;
    endfunction

endpackage

// ===== hdl/qenc_if.sv =====
// handshake channels: sample items, report items and the configuration write
interface qenc_sample_if;
    import qenc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [3:0]              pin_a_levels;
    logic [3:0]              pin_b_levels;
    logic [BUTTON_WIDTH-1:0] button_levels;
    logic                    switch_level;
    logic                    host_ready;

    modport source (output valid, pin_a_levels, pin_b_levels, button_levels,
                    switch_level, host_ready, input ready);
    modport sink   (input valid, pin_a_levels, pin_b_levels, button_levels,
                    switch_level, host_ready, output ready);
endinterface

interface qenc_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte0;
    logic [7:0] report_byte1;
    logic [7:0] report_byte2;

    modport source (output valid, report_byte0, report_byte1, report_byte2,
                    input ready);
    modport sink   (input valid, report_byte0, report_byte1, report_byte2,
                    output ready);
endinterface

interface qenc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/quad_encoder_button_reporter.sv =====
// top level: quadrature encoder and button reporter
//
// sample (sink): one item per sample of the encoder pins, the 15 active-low
//   buttons, the toggle switch and the host-ready flag; each item is also one
//   tick of the hold timer
// report (source): three report bytes, sent only when the host is ready and
//   the report differs from the last one sent; many items give no report
// cfg (sink): write of hold_ticks, taken in any cycle; write it only while idle
// latency: a report is valid one cycle after its item is accepted (the item is
//   worked from the input register straight into the result register)
// throughput: one item per cycle; the only stall is a report still held in
//   the result register when the next item is due to be worked
// a stalled report receiver holds the result register and, behind it, the
//   input register; sample.ready drops once both are full
// reset clears counts, directions, switch flag, hold timer, accumulator and
//   last report; hold_ticks returns to 1563; the first item after reset loads
//   the switch reference without raising the flag
module quad_encoder_button_reporter
    import qenc_pkg::*;
#(
    parameter int NUM_ENCODERS = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    qenc_sample_if.sink   sample,
    qenc_report_if.source report,
    qenc_cfg_if.sink      cfg
);

    localparam int REPORTED = (NUM_ENCODERS < REPORT_ENC_MAX) ? NUM_ENCODERS
                                                               : REPORT_ENC_MAX;

    // input register
    logic                    in_valid_reg;
    logic [3:0]              pin_a_reg;
    logic [3:0]              pin_b_reg;
    logic [BUTTON_WIDTH-1:0] buttons_reg;
    logic                    switch_reg;
    logic                    host_ready_reg;

    // block state
    logic [15:0]             hold_ticks_reg;
    logic                    primed_reg;
    logic                    switch_ref_reg;
    logic                    switch_flag_reg, switch_flag_next;
    logic [BUTTON_WIDTH-1:0] accum_reg, accum_next;
    logic [23:0]             last_report_reg;

    // result register
    logic                    out_valid_reg;
    logic [23:0]             out_data_reg;

    logic                    advance;
    logic                    switch_change;
    logic                    switch_flag_now;
    logic [BUTTON_WIDTH-1:0] accum_now;
    logic                    any_detent;
    logic                    hold_elapsed;
    logic                    clear_latched;
    logic [7:0]              dir_byte;
    logic [23:0]             report_now;
    logic                    emit;
    enc_status_t             enc_status [NUM_ENCODERS];
    logic [NUM_ENCODERS-1:0] detents;

    // work the held item once the result register has room
    assign advance      = in_valid_reg & (~out_valid_reg | report.ready);
    assign sample.ready = ~in_valid_reg | advance;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (sample.ready) begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid) begin
            pin_a_reg      <= sample.pin_a_levels;
            pin_b_reg      <= sample.pin_b_levels;
            buttons_reg    <= sample.button_levels;
            switch_reg     <= sample.switch_level;
            host_ready_reg <= sample.host_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_ticks_reg <= HOLD_TICKS_RESET;
        end else if (cfg.valid) begin
            hold_ticks_reg <= cfg.data;
        end
    end

    // switch edge: the reference always follows the sampled level
    assign switch_change   = primed_reg & (switch_reg != switch_ref_reg);
    assign switch_flag_now = switch_flag_reg | switch_change;

    // per-encoder decoders; encoders past the fourth see pins held low
    genvar gi;
    generate
        for (gi = 0; gi < NUM_ENCODERS; gi++) begin : g_enc
            logic pin_a;
            logic pin_b;
            if (gi < REPORT_ENC_MAX) begin : g_pins
                assign pin_a = pin_a_reg[gi];
                assign pin_b = pin_b_reg[gi];
            end else begin : g_nopins
                assign pin_a = 1'b0;
                assign pin_b = 1'b0;
            end
            qenc_decoder u_decoder (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .clear_dir (clear_latched),
                .pin_a     (pin_a),
                .pin_b     (pin_b),
                .status    (enc_status[gi])
            );
            assign detents[gi] = enc_status[gi].detent;
        end
    endgenerate

    assign any_detent = |detents;

    qenc_hold_timer u_hold_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .restart    (any_detent | switch_change),
        .hold_ticks (hold_ticks_reg),
        .elapsed    (hold_elapsed)
    );

    // latched events clear after a report slot once the hold has run out
    assign clear_latched = host_ready_reg & hold_elapsed;
    assign accum_now     = accum_reg | ~buttons_reg;

    always_comb
    begin
        dir_byte = '0;
        for (int i = 0; i < REPORTED; i++) begin
            if (enc_status[i].dir == DIR_LEFT) begin
                dir_byte[2*i] = 1'b1;
            end else if (enc_status[i].dir == DIR_RIGHT) begin
                dir_byte[2*i+1] = 1'b1;
            end
        end
        report_now = {dir_byte, switch_flag_now, accum_now[14:8], accum_now[7:0]};
        emit       = host_ready_reg & (report_now != last_report_reg);
        accum_next = host_ready_reg ? '0 : accum_now;
        switch_flag_next = clear_latched ? 1'b0 : switch_flag_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            primed_reg      <= 1'b0;
            switch_ref_reg  <= 1'b0;
            switch_flag_reg <= 1'b0;
            accum_reg       <= '0;
            last_report_reg <= '0;
        end else if (advance) begin
            primed_reg      <= 1'b1;
            switch_ref_reg  <= switch_reg;
            switch_flag_reg <= switch_flag_next;
            accum_reg       <= accum_next;
            if (emit) begin
                last_report_reg <= report_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (report.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit) begin
            out_data_reg <= report_now;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.report_byte0 = out_data_reg[7:0];
    assign report.report_byte1 = out_data_reg[15:8];
    assign report.report_byte2 = out_data_reg[23:16];

endmodule

// ===== hdl/qenc_decoder.sv =====
// full-step decoder for one encoder: step count, last pins and latched direction
module qenc_decoder
    import qenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        clear_dir,
    input  logic        pin_a,
    input  logic        pin_b,
    output enc_status_t status
);

    step_count_t  count_reg, count_next;
    logic [1:0]   prev_reg;
    direction_t   dir_reg, dir_next;
    rule_result_t after_a;
    rule_result_t after_b;

    always_comb
    begin
        after_a = '{count: count_reg, dir: dir_reg, detent: 1'b0};
        if (pin_a != prev_reg[1]) begin
            after_a = apply_rule(count_reg, dir_reg, pin_a, pin_b, 1'b0);
        end
        after_b = '{count: after_a.count, dir: after_a.dir, detent: 1'b0};
        if (pin_b != prev_reg[0]) begin
            after_b = apply_rule(after_a.count, after_a.dir, pin_a, pin_b, 1'b1);
        end
        status.dir    = after_b.dir;
        status.detent = after_a.detent | after_b.detent;
        count_next    = after_b.count;
        dir_next      = clear_dir ? DIR_NONE : after_b.dir;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 4'sd0;
            prev_reg  <= 2'b11;
            dir_reg   <= DIR_NONE;
        end else if (advance) begin
            count_reg <= count_next;
            prev_reg  <= {pin_a, pin_b};
            dir_reg   <= dir_next;
        end
    end

endmodule

// ===== hdl/qenc_hold_timer.sv =====
// hold timer: ticks once per item, restarted by a detent or a switch change
module qenc_hold_timer
    import qenc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        restart,
    input  logic [15:0] hold_ticks,
    output logic        elapsed
);

    logic [15:0] counter_reg, counter_next;
    logic        elapsed_reg;
    logic [16:0] tick;
    logic        expired;

    always_comb
    begin
        tick    = {1'b0, counter_reg} + 17'd1;
        expired = tick >= {1'b0, hold_ticks};
        elapsed = (elapsed_reg | expired) & ~restart;
        if (restart || expired) begin
            counter_next = '0;
        end else begin
            counter_next = tick[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            counter_reg <= '0;
            elapsed_reg <= 1'b0;
        end else if (advance) begin
            counter_reg <= counter_next;
            elapsed_reg <= elapsed;
        end
    end

endmodule

// ===== bench/qenc_bench_pkg.sv =====
// report predictor and report checker for the encoder reporter bench
`timescale 1ns / 100ps
package qenc_bench_pkg;
    import qenc_pkg::*;

    typedef struct packed {
        logic [3:0]              pin_a;
        logic [3:0]              pin_b;
        logic [BUTTON_WIDTH-1:0] buttons;
        logic                    sw;
        logic                    host_ready;
    } sample_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } report_t;

    class report_scoreboard;
        logic [15:0]             hold_ticks;
        step_count_t             steps [REPORT_ENC_MAX];
        direction_t              dirs [REPORT_ENC_MAX];
        logic [1:0]              last_pins [REPORT_ENC_MAX];
        logic                    sw_ref;
        logic                    primed;
        logic                    sw_flag;
        logic [15:0]             hold_count;
        logic                    hold_done;
        logic [BUTTON_WIDTH-1:0] pressed;
        report_t                 last_sent;
        report_t                 reports_due [$];
        int                      mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            int i;
            hold_ticks = HOLD_TICKS_RESET;
            for (i = 0; i < REPORT_ENC_MAX; i++)
            begin
                steps[i]     = 4'sd0;
                dirs[i]      = DIR_NONE;
                last_pins[i] = 2'b11;
            end
            sw_ref     = 1'b0;
            primed     = 1'b0;
            sw_flag    = 1'b0;
            hold_count = 16'd0;
            hold_done  = 1'b0;
            pressed    = '0;
            last_sent  = '0;
            reports_due.delete();
        endfunction

        function void set_hold(logic [15:0] value);
            hold_ticks = value;
        endfunction

        // one rule set of one encoder, then detent latch and rest clear
        function void step_encoder(int i, logic a, logic b, logic on_b);
            step_count_t c;
            logic        down;
            logic        up;
            c = steps[i];
            if (on_b)
            begin
                down = (c == -4'sd1 && !a && !b) || (c == -4'sd3 && a && b);
                up   = (c == 4'sd0 && a && !b) || (c == 4'sd2 && !a && b);
            end
            else
            begin
                down = (c == 4'sd0 && !a && b) || (c == -4'sd2 && a && !b);
                up   = (c == 4'sd1 && !a && !b) || (c == 4'sd3 && a && b);
            end
            if (down)
                c = c - 4'sd1;
            else if (up)
                c = c + 4'sd1;
            if (c == COUNT_RIGHT || c == COUNT_LEFT)
            begin
                dirs[i]    = (c == COUNT_RIGHT) ? DIR_RIGHT : DIR_LEFT;
                c          = 4'sd0;
                hold_count = 16'd0;
                hold_done  = 1'b0;
            end
            if (a && b)
                c = 4'sd0;
            steps[i] = c;
        endfunction

        function void take_sample(sample_t s);
            logic [16:0] next_count;
            logic [1:0]  now;
            logic [1:0]  changed;
            report_t     r;
            int          i;
            next_count = {1'b0, hold_count} + 17'd1;
            if (next_count >= {1'b0, hold_ticks})
            begin
                hold_done  = 1'b1;
                hold_count = 16'd0;
            end
            else
                hold_count = next_count[15:0];

            if (!primed)
            begin
                sw_ref = s.sw;
                primed = 1'b1;
            end
            else if (s.sw != sw_ref)
            begin
                sw_flag    = 1'b1;
                sw_ref     = s.sw;
                hold_count = 16'd0;
                hold_done  = 1'b0;
            end

            for (i = 0; i < REPORT_ENC_MAX; i++)
            begin
                now          = {s.pin_a[i], s.pin_b[i]};
                changed      = now ^ last_pins[i];
                last_pins[i] = now;
                if (changed[1])
                    step_encoder(i, now[1], now[0], 1'b0);
                if (changed[0])
                    step_encoder(i, now[1], now[0], 1'b1);
            end

            pressed = pressed | ~s.buttons;

            if (s.host_ready)
            begin
                r.byte0 = pressed[7:0];
                r.byte1 = {sw_flag, pressed[14:8]};
                r.byte2 = 8'd0;
                for (i = 0; i < REPORT_ENC_MAX; i++)
                begin
                    if (dirs[i] == DIR_LEFT)
                        r.byte2[2*i] = 1'b1;
                    else if (dirs[i] == DIR_RIGHT)
                        r.byte2[2*i+1] = 1'b1;
                end
                if (r != last_sent)
                begin
                    last_sent = r;
                    reports_due.push_back(r);
                end
                pressed = '0;
                if (hold_done)
                begin
                    for (i = 0; i < REPORT_ENC_MAX; i++)
                        dirs[i] = DIR_NONE;
                    sw_flag = 1'b0;
                end
            end
        endfunction

        function void compare_report(report_t got);
            report_t want;
            if (reports_due.size() == 0)
            begin
                $error("report %h %h %h with none expected", got.byte0, got.byte1, got.byte2);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            if (got.byte0 !== want.byte0)
            begin
                $error("report_byte0: expected %h, got %h", want.byte0, got.byte0);
                mismatches++;
            end
            if (got.byte1 !== want.byte1)
            begin
                $error("report_byte1: expected %h, got %h", want.byte1, got.byte1);
                mismatches++;
            end
            if (got.byte2 !== want.byte2)
            begin
                $error("report_byte2: expected %h, got %h", want.byte2, got.byte2);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return reports_due.size();
        endfunction
    endclass

endpackage

// ===== bench/quad_encoder_button_reporter_test.sv =====
// top level bench: drives samples and hold writes, checks every report
`timescale 1ns / 100ps
module quad_encoder_button_reporter_test;
    import qenc_pkg::*;
    import qenc_bench_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 6;

    logic clk;
    logic rst_n;

    // chances in percent, changed per phase
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // cycles in a row with no handshake on any channel
    int quiet_cycles = 0;

    report_scoreboard board;

    // detent cycle position per encoder: 0 is both high, counting up turns right
    logic [1:0] gray_pos [REPORT_ENC_MAX];
    int         spin [REPORT_ENC_MAX];
    logic       sw_now;

    qenc_sample_if sample_ch ();
    qenc_report_if report_ch ();
    qenc_cfg_if    cfg_ch ();

    quad_encoder_button_reporter #(
        .NUM_ENCODERS(4)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch),
        .report(report_ch),
        .cfg(cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // report receiver, stalls at random
    always @(posedge clk)
    begin
        report_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // every accepted report goes against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && report_ch.valid && report_ch.ready)
            board.compare_report({report_ch.report_byte0, report_ch.report_byte1,
                                  report_ch.report_byte2});
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one item, with a random gap first, and note it once taken
    task automatic send_sample(input sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.pin_a_levels  <= s.pin_a;
        sample_ch.pin_b_levels  <= s.pin_b;
        sample_ch.button_levels <= s.buttons;
        sample_ch.switch_level  <= s.sw;
        sample_ch.host_ready    <= s.host_ready;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        board.take_sample(s);
    endtask

    task automatic drive_item(input logic [3:0] a, input logic [3:0] b,
                              input logic [14:0] btn, input logic sw, input logic rdy);
        send_sample('{pin_a: a, pin_b: b, buttons: btn, sw: sw, host_ready: rdy});
    endtask

    // hold the sender off until every predicted report has come back
    task automatic drain_reports();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
    endtask

    // hold_ticks is only written with the block idle; items that give no
    // report may still be in the pipeline, hence the extra cycles
    task automatic write_hold(input logic [15:0] value);
        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        board.set_hold(value);
    endtask

    // mostly clean turns with a preferred spin, some backing off, some pin noise
    function automatic sample_t random_sample();
        sample_t     s;
        logic [14:0] press;
        int          k;
        int          roll;
        for (k = 0; k < REPORT_ENC_MAX; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                gray_pos[k] = 2'(gray_pos[k] + spin[k]);
            else if (roll < 60)
                gray_pos[k] = 2'(gray_pos[k] - spin[k]);
            if (gray_pos[k] == 2'd0 && $urandom_range(0, 1) == 1)
                spin[k] = -spin[k];
            s.pin_a[k] = (gray_pos[k] == 2'd0) || (gray_pos[k] == 2'd1);
            s.pin_b[k] = (gray_pos[k] == 2'd0) || (gray_pos[k] == 2'd3);
            if (roll >= 95)
            begin
                s.pin_a[k] = 1'($urandom_range(0, 1));
                s.pin_b[k] = 1'($urandom_range(0, 1));
            end
        end
        case ($urandom_range(0, 3))
            0: press = '0;
            1: press = 15'd1 << $urandom_range(0, 14);
            2: press = 15'($urandom_range(0, 32767));
            default: press = 15'($urandom & $urandom);
        endcase
        s.buttons = ~press;
        if ($urandom_range(0, 15) == 0)
            sw_now = ~sw_now;
        s.sw         = sw_now;
        s.host_ready = ($urandom_range(0, 9) < 6);
        return s;
    endfunction

    // hold setting, idling and stall patterns, then random items with one full pause midway
    task automatic run_phase(input logic [15:0] hold, input int idle_pct,
                             input int stall, input int count);
        int n;
        write_hold(hold);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain_reports();
            send_sample(random_sample());
        end
    endtask

    // short directed run at the reset hold setting
    task automatic directed_items();
        // first sample loads the switch reference, report equals the reset one
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b1, 1'b1);
        // every button pressed while the host is busy, then reported
        drive_item(4'hF, 4'hF, 15'h0000, 1'b1, 1'b0);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b1, 1'b1);
        // accumulator cleared, then an unchanged report gives nothing
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b1, 1'b1);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b1, 1'b1);
        // switch change raises the flag
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b0, 1'b1);
        // full detent to the right on all encoders
        drive_item(4'hF, 4'h0, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'h0, 4'h0, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'h0, 4'hF, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b0, 1'b1);
        // full detent to the left overrides it
        drive_item(4'h0, 4'hF, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'h0, 4'h0, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'hF, 4'h0, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b0, 1'b1);
        // both pins changing in one sample, there and back
        drive_item(4'h0, 4'h0, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b0, 1'b0);
        // half a step and back to rest clears the count
        drive_item(4'hF, 4'h0, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'h0, 4'hF, 15'h7FFF, 1'b0, 1'b0);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b0, 1'b1);
        // mixed pins per encoder, alternating buttons
        drive_item(4'b0101, 4'b1010, 15'h2AAA, 1'b1, 1'b1);
        drive_item(4'hF, 4'hF, 15'h5555, 1'b1, 1'b1);
        drive_item(4'hF, 4'hF, 15'h7FFF, 1'b1, 1'b1);
    endtask

    initial
    begin
        board = new();
        for (int k = 0; k < REPORT_ENC_MAX; k++)
        begin
            gray_pos[k] = 2'd0;
            spin[k]     = (k % 2 == 0) ? 1 : -1;
        end
        sw_now = 1'b0;

        // known levels on every input from time zero
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.pin_a_levels  = 4'hF;
        sample_ch.pin_b_levels  = 4'hF;
        sample_ch.button_levels = 15'h7FFF;
        sample_ch.switch_level  = 1'b0;
        sample_ch.host_ready    = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.data             = 16'd0;
        report_ch.ready         = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        // hold settings from the smallest, the largest and some in between, idling and stall patterns varied
        run_phase(16'd1, 0, 0, 110);
        run_phase(16'd65535, 78, 0, 110);
        run_phase(16'd3, 0, 78, 110);
        run_phase(16'($urandom_range(2, 60)), 13, 13, 110);
        run_phase(16'd12, 0, 0, 110);
        run_phase(16'($urandom_range(1, 400)), 78, 78, 110);

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/qenc_pkg.sv
hdl/qenc_if.sv
hdl/qenc_decoder.sv
hdl/qenc_hold_timer.sv
hdl/quad_encoder_button_reporter.sv
bench/qenc_bench_pkg.sv
bench/quad_encoder_button_reporter_test.sv
